### sv/mono_bitmap_raster_engine_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the monochrome raster engine
// Concurrent checks, clocked on the rising edge, quiet while in reset.
// ---------------------------------------------------------------------------
`ifndef MONO_BITMAP_RASTER_ENGINE_UNIT_ASSERT_SVH
`define MONO_BITMAP_RASTER_ENGINE_UNIT_ASSERT_SVH

// same-cycle implication
`define MBRE_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MBRE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/mbre_pkg.sv
// ---------------------------------------------------------------------------
// mbre_pkg
// Shared constants and types of the monochrome raster engine.
// ---------------------------------------------------------------------------
package mbre_pkg;

   // wide enough for any row/column product the registers allow
   localparam int FULL_ADDR_W = 21;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 11;

   typedef logic [FULL_ADDR_W-1:0] addr_type;

   // command codes
   localparam logic [2:0] ACT_PUT_DOT  = 3'd0;
   localparam logic [2:0] ACT_GET_DOT  = 3'd1;
   localparam logic [2:0] ACT_GET_SEG  = 3'd2;
   localparam logic [2:0] ACT_XOR_RECT = 3'd3;
   localparam logic [2:0] ACT_FILL     = 3'd4;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_BYTES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS      = 2'd1;

   localparam logic [8:0]  ROW_BYTES_RST = 9'd40;
   localparam logic [10:0] ROWS_RST      = 11'd200;

   localparam logic [7:0] BYTE_ONES = 8'hFF;
   localparam logic [7:0] LEFT_BIT  = 8'h80;

   // one byte access: new = ((old & keep) | set) ^ flip
   typedef struct packed {
      logic       valid;
      logic       wr;
      addr_type   addr;
      logic [7:0] keep;
      logic [7:0] set;
      logic [7:0] flip;
   } store_op_type;

endpackage

### sv/mbre_store.sv
// ---------------------------------------------------------------------------
// mbre_store
// Bitmap byte memory with a registered read-modify-write path. Accesses
// outside the memory read as zero and write nothing.
// ---------------------------------------------------------------------------
module mbre_store #(
   parameter int MEM_BYTES = 32768
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mbre_pkg::store_op_type op,
   output logic [7:0]            rd_data
);

   localparam int AW = $clog2(MEM_BYTES);
   localparam mbre_pkg::addr_type MEM_END = mbre_pkg::addr_type'(MEM_BYTES);

   logic [7:0] mem_array [MEM_BYTES];

   logic                  hit_in;
   logic                  s1_act_ff;
   mbre_pkg::store_op_type s1_op_ff;
   logic [7:0]            mem_q_ff;
   logic                  wr_valid_in;
   logic                  wr_valid_ff;
   logic [AW-1:0]         wr_addr_ff;
   logic [7:0]            wr_data_ff;
   logic [7:0]            old_byte;
   logic [7:0]            new_byte;

   assign hit_in = op.valid && (op.addr < MEM_END);

   // the write of the previous edge is not yet visible in mem_q_ff
   always_comb begin
      if (!s1_act_ff) begin
         old_byte = 8'h00;
      end else if (wr_valid_ff && (wr_addr_ff == s1_op_ff.addr[AW-1:0])) begin
         old_byte = wr_data_ff;
      end else begin
         old_byte = mem_q_ff;
      end
   end

   assign new_byte    = ((old_byte & s1_op_ff.keep) | s1_op_ff.set) ^ s1_op_ff.flip;
   assign wr_valid_in = s1_act_ff && s1_op_ff.wr;
   assign rd_data     = old_byte;

   always_ff @(posedge clock) begin
      if (hit_in) begin
         mem_q_ff <= mem_array[op.addr[AW-1:0]];
      end
      if (wr_valid_in) begin
         mem_array[s1_op_ff.addr[AW-1:0]] <= new_byte;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff   <= op;
      wr_addr_ff <= s1_op_ff.addr[AW-1:0];
      wr_data_ff <= new_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_act_ff   <= 1'b0;
         wr_valid_ff <= 1'b0;
      end else begin
         s1_act_ff   <= hit_in;
         wr_valid_ff <= wr_valid_in;
      end
   end

endmodule

### sv/mono_bitmap_raster_engine_unit.sv
// ---------------------------------------------------------------------------
// mono_bitmap_raster_engine_unit
// One-bit-per-pixel bitmap engine: dots, segment reads, XOR boxes, fill.
// ---------------------------------------------------------------------------
// Usage:
//   req_* carries one command word (action, x, y, span_width, rect_height,
//   color); it is taken when req_valid is high and req_stall low. rsp_*
//   returns the pixel words of get dot and get segment, with rsp_last on
//   the final pixel; rsp_stall holds the output register.
//   csr_* writes row_bytes (index 0) and rows (index 1) while idle.
// Steps (one byte access per cycle on the single memory port):
//   every command first passes the row multiply and the address set-up.
//   put dot: one read-modify-write. get dot: one byte read, then the pixel word.
//   get segment: each byte is fetched, then its pixels go out one by one.
//   XOR box: one access per byte of each clipped row, over the clipped rows.
//   fill: one write to each of min(row_bytes*rows, MEM_BYTES) bytes.
//   One command is worked on at a time; the next one is taken as soon as
//   the last pixel word sits in the output register.
// Reset: row_bytes = 40, rows = 200, no result pending. The bitmap is not
//   cleared; issue a fill before reading it.
// A stalled receiver holds the output word and pauses a segment read.
// ---------------------------------------------------------------------------
`include "mono_bitmap_raster_engine_unit_assert.svh"

module mono_bitmap_raster_engine_unit #(
   parameter int MEM_BYTES = 32768,
   parameter int MAX_SPAN  = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [2:0]                      req_action,
   input  logic [10:0]                     req_x,
   input  logic [9:0]                      req_y,
   input  logic [10:0]                     req_span_width,
   input  logic [9:0]                      req_rect_height,
   input  logic                            req_color,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_pixel,
   output logic                            rsp_last,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mbre_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [mbre_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CNT_W = $clog2(MAX_SPAN + 1);
   localparam mbre_pkg::addr_type MEM_END = mbre_pkg::addr_type'(MEM_BYTES);

   typedef enum logic [8:0] {
      ST_IDLE = 9'b000000001,
      ST_MUL  = 9'b000000010,
      ST_PREP = 9'b000000100,
      ST_PUT  = 9'b000001000,
      ST_RD   = 9'b000010000,
      ST_RDW  = 9'b000100000,
      ST_EMIT = 9'b001000000,
      ST_BOX  = 9'b010000000,
      ST_FILL = 9'b100000000
   } state_type;

   state_type state_ff, state_in;

   // command word
   logic [2:0]  action_ff;
   logic [10:0] x_ff;
   logic [9:0]  y_ff;
   logic [10:0] w_ff;
   logic [9:0]  h_ff;
   logic        color_ff;

   logic [8:0]  row_bytes_ff, row_bytes_in;
   logic [10:0] rows_ff, rows_in;

   // set-up results
   logic [19:0] prod_ff, prod_in;
   logic [7:0]  smask_ff, smask_in;
   logic [7:0]  emask_ff, emask_in;
   logic [8:0]  last_b_ff, last_b_in;
   logic        skip_ff, skip_in;
   logic [9:0]  nrows_ff, nrows_in;
   logic        dot_ok_ff, dot_ok_in;

   // walk state
   mbre_pkg::addr_type addr_ff, addr_in;
   mbre_pkg::addr_type row_start_ff, row_start_in;
   mbre_pkg::addr_type fill_end_ff, fill_end_in;
   logic [8:0]       b_ff, b_in;
   logic [9:0]       row_left_ff, row_left_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [2:0]       bitpos_ff, bitpos_in;
   logic [7:0]       byte_ff, byte_in;
   logic             rd_en_ff, rd_en_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_pixel_ff, rsp_pixel_in;
   logic rsp_last_ff, rsp_last_in;

   logic        accept;
   logic        out_free;
   logic        emit_load;
   logic [8:0]  sb9;
   logic [11:0] xe;
   logic [8:0]  eb;
   logic [7:0]  sm;
   logic [7:0]  em;
   logic        single;
   logic        clip;
   logic [10:0] y_ext;
   logic [11:0] y_plus_h;
   logic [10:0] mul_a;
   logic [CNT_W-1:0] span_n;
   logic [7:0]  put_bit;
   logic [7:0]  box_mask;
   mbre_pkg::addr_type prep_addr;
   mbre_pkg::addr_type prod_wide;

   mbre_pkg::store_op_type op;
   logic [7:0]             rd_data;

   assign accept    = req_valid && !req_stall;
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign emit_load = (state_ff == ST_EMIT) && out_free;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;
   assign rsp_last  = rsp_last_ff;

   // box geometry
   assign sb9      = {1'b0, x_ff[10:3]};
   assign xe       = {1'b0, x_ff} + {1'b0, w_ff};
   assign eb       = xe[11:3];
   assign sm       = mbre_pkg::BYTE_ONES >> x_ff[2:0];
   assign em       = ~(mbre_pkg::BYTE_ONES >> xe[2:0]);
   assign single   = (sb9 == eb);
   assign clip     = !single && (eb >= row_bytes_ff);
   assign y_ext    = {1'b0, y_ff};
   assign y_plus_h = {2'b00, h_ff} + {1'b0, y_ext};

   assign mul_a     = (action_ff == mbre_pkg::ACT_FILL) ? rows_ff : y_ext;
   assign span_n    = (w_ff > 11'(MAX_SPAN)) ? CNT_W'(MAX_SPAN) : CNT_W'(w_ff);
   assign put_bit   = mbre_pkg::LEFT_BIT >> x_ff[2:0];
   assign prod_wide = {1'b0, prod_ff};
   assign prep_addr = prod_wide + mbre_pkg::addr_type'(sb9);

   always_comb begin
      if (b_ff == sb9) begin
         box_mask = smask_ff;
      end else if ((b_ff == last_b_ff) && (emask_ff != 8'h00)) begin
         box_mask = emask_ff;
      end else begin
         box_mask = mbre_pkg::BYTE_ONES;
      end
   end

   // memory access per state
   always_comb begin
      op       = '0;
      op.addr  = addr_ff;
      op.keep  = mbre_pkg::BYTE_ONES;
      case (state_ff)
         ST_PUT: begin
            op.valid = dot_ok_ff;
            op.wr    = 1'b1;
            op.keep  = ~put_bit;
            op.set   = color_ff ? put_bit : 8'h00;
         end
         ST_RD: begin
            op.valid = rd_en_ff;
         end
         ST_BOX: begin
            op.valid = 1'b1;
            op.wr    = 1'b1;
            op.flip  = box_mask;
         end
         ST_FILL: begin
            op.valid = 1'b1;
            op.wr    = 1'b1;
            op.keep  = 8'h00;
            op.set   = {8{color_ff}};
         end
         default: begin
            op.valid = 1'b0;
         end
      endcase
   end

   mbre_store #(
      .MEM_BYTES (MEM_BYTES)
   ) u_store (
      .clock   (clock),
      .reset   (reset),
      .op      (op),
      .rd_data (rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      row_bytes_in = row_bytes_ff;
      rows_in      = rows_ff;
      prod_in      = prod_ff;
      smask_in     = smask_ff;
      emask_in     = emask_ff;
      last_b_in    = last_b_ff;
      skip_in      = skip_ff;
      nrows_in     = nrows_ff;
      dot_ok_in    = dot_ok_ff;
      addr_in      = addr_ff;
      row_start_in = row_start_ff;
      fill_end_in  = fill_end_ff;
      b_in         = b_ff;
      row_left_in  = row_left_ff;
      rem_in       = rem_ff;
      bitpos_in    = bitpos_ff;
      byte_in      = byte_ff;
      rd_en_in     = rd_en_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pixel_in = rsp_pixel_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            mbre_pkg::CSR_ROW_BYTES: row_bytes_in = csr_wdata[8:0];
            mbre_pkg::CSR_ROWS:      rows_in      = csr_wdata;
            default:                 rows_in      = rows_ff;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in   = {9'b0, mul_a} * {11'b0, row_bytes_ff};
            skip_in   = (sb9 >= row_bytes_ff);
            dot_ok_in = (sb9 < row_bytes_ff) && (y_ext < rows_ff);
            smask_in  = single ? (sm & em) : sm;
            emask_in  = (single || clip) ? 8'h00 : em;
            if (single) begin
               last_b_in = sb9;
            end else if (clip) begin
               last_b_in = row_bytes_ff - 9'd1;
            end else if (em != 8'h00) begin
               last_b_in = eb;
            end else begin
               last_b_in = eb - 9'd1;
            end
            if (y_ext >= rows_ff) begin
               nrows_in = 10'd0;
            end else if (y_plus_h > {1'b0, rows_ff}) begin
               nrows_in = 10'(rows_ff - y_ext);
            end else begin
               nrows_in = h_ff;
            end
            state_in = ST_PREP;
         end
         ST_PREP: begin
            addr_in      = prep_addr;
            row_start_in = prep_addr;
            bitpos_in    = x_ff[2:0];
            b_in         = sb9;
            row_left_in  = nrows_ff;
            fill_end_in  = (prod_wide > MEM_END) ? MEM_END : prod_wide;
            case (action_ff)
               mbre_pkg::ACT_PUT_DOT: begin
                  state_in = ST_PUT;
               end
               mbre_pkg::ACT_GET_DOT: begin
                  rem_in   = CNT_W'(1);
                  rd_en_in = dot_ok_ff;
                  state_in = ST_RD;
               end
               mbre_pkg::ACT_GET_SEG: begin
                  rem_in   = span_n;
                  rd_en_in = 1'b1;
                  state_in = (span_n == '0) ? ST_IDLE : ST_RD;
               end
               mbre_pkg::ACT_XOR_RECT: begin
                  state_in = (skip_ff || (nrows_ff == 10'd0)) ? ST_IDLE : ST_BOX;
               end
               mbre_pkg::ACT_FILL: begin
                  addr_in  = '0;
                  state_in = (prod_ff == 20'd0) ? ST_IDLE : ST_FILL;
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end
         ST_PUT: begin
            state_in = ST_IDLE;
         end
         ST_RD: begin
            state_in = ST_RDW;
         end
         ST_RDW: begin
            byte_in  = rd_data;
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_pixel_in = byte_ff[~bitpos_ff];
               rsp_last_in  = (rem_ff == CNT_W'(1));
               rem_in       = rem_ff - CNT_W'(1);
               bitpos_in    = bitpos_ff + 3'd1;
               if (rem_ff == CNT_W'(1)) begin
                  state_in = ST_IDLE;
               end else if (bitpos_ff == 3'd7) begin
                  // byte used up: fetch the next one
                  addr_in  = addr_ff + mbre_pkg::addr_type'(1);
                  state_in = ST_RD;
               end
            end
         end
         ST_BOX: begin
            if (b_ff == last_b_ff) begin
               if (row_left_ff == 10'd1) begin
                  state_in = ST_IDLE;
               end else begin
                  // advance to the left edge of the next row
                  row_left_in  = row_left_ff - 10'd1;
                  row_start_in = row_start_ff + mbre_pkg::addr_type'(row_bytes_ff);
                  addr_in      = row_start_ff + mbre_pkg::addr_type'(row_bytes_ff);
                  b_in         = sb9;
               end
            end else begin
               b_in    = b_ff + 9'd1;
               addr_in = addr_ff + mbre_pkg::addr_type'(1);
            end
         end
         ST_FILL: begin
            addr_in = addr_ff + mbre_pkg::addr_type'(1);
            if (addr_in == fill_end_ff) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         row_bytes_ff <= mbre_pkg::ROW_BYTES_RST;
         rows_ff      <= mbre_pkg::ROWS_RST;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         row_bytes_ff <= row_bytes_in;
         rows_ff      <= rows_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         action_ff <= req_action;
         x_ff      <= req_x;
         y_ff      <= req_y;
         w_ff      <= req_span_width;
         h_ff      <= req_rect_height;
         color_ff  <= req_color;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff      <= prod_in;
      smask_ff     <= smask_in;
      emask_ff     <= emask_in;
      last_b_ff    <= last_b_in;
      skip_ff      <= skip_in;
      nrows_ff     <= nrows_in;
      dot_ok_ff    <= dot_ok_in;
      addr_ff      <= addr_in;
      row_start_ff <= row_start_in;
      fill_end_ff  <= fill_end_in;
      b_ff         <= b_in;
      row_left_ff  <= row_left_in;
      rem_ff       <= rem_in;
      bitpos_ff    <= bitpos_in;
      byte_ff      <= byte_in;
      rd_en_ff     <= rd_en_in;
      rsp_pixel_ff <= rsp_pixel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   `MBRE_ASSERT_NEXT(a_accept_starts, clock, reset, accept, state_ff == ST_MUL, "accepted word did not start the set-up")
   `MBRE_ASSERT_NEXT(a_last_ends_run, clock, reset, emit_load && (rem_ff == CNT_W'(1)), (state_ff == ST_IDLE) && rsp_valid_ff && rsp_last_ff, "final pixel did not close the read run")
   `MBRE_ASSERT_IMPLY(a_box_col_bound, clock, reset, state_ff == ST_BOX, b_ff <= last_b_ff, "box walk passed the last byte of the row")
   `MBRE_ASSERT_IMPLY(a_emit_count, clock, reset, state_ff == ST_EMIT, rem_ff != '0, "emitting with no pixels left")

endmodule

### test/tb_mono_bitmap_raster_engine_unit.sv
// ---------------------------------------------------------------------------
// tb_mono_bitmap_raster_engine_unit
// Drives command words into the raster engine and checks every pixel word
// against a local bitmap model or a typed row's pixel. A directed table
// covers the corners of the store and every command. Random phases under
// several raster settings follow; all but one idle both channels at random.
// ---------------------------------------------------------------------------
module tb_mono_bitmap_raster_engine_unit;

   localparam int MEM_BYTES       = 32768;
   localparam int MAX_SPAN        = 64;
   localparam int QUIET_LIMIT     = 100000;
   localparam int DRAIN_CYCLES    = 16;
   localparam int PHASES          = 6;
   localparam int ITEMS_PER_PHASE = 50;
   localparam int XOR_BUDGET      = 2048;
   localparam int FILL_BUDGET     = 8192;
   localparam int IDLE_PCT        = 28;
   localparam logic [2:0] ACT_RSVD_LO = 3'd5;
   localparam logic [2:0] ACT_RSVD_HI = 3'd7;

   typedef struct packed {
      logic [2:0]  action;
      logic [10:0] x;
      logic [9:0]  y;
      logic [10:0] span;
      logic [9:0]  height;
      logic        color;
   } raster_cmd_type;

   typedef struct packed {
      logic pixel;
      logic last;
   } pixel_word_type;

   typedef struct packed {
      logic [2:0]  action;
      logic [10:0] x;
      logic [9:0]  y;
      logic [10:0] span;
      logic [9:0]  height;
      logic        color;
      logic        typed;
      logic        exp_pixel;
   } dir_row_type;

   localparam int DIR_ROWS = 25;

   // typed rows are get dot with a known pixel; last is always set there
   dir_row_type dir_tab [0:DIR_ROWS-1] = '{
      '{mbre_pkg::ACT_FILL,     11'd0,    10'd0,    11'd0,    10'd0,    1'b0, 1'b0, 1'b0},
      '{mbre_pkg::ACT_GET_DOT,  11'd0,    10'd0,    11'd0,    10'd0,    1'b0, 1'b1, 1'b0},
      '{mbre_pkg::ACT_PUT_DOT,  11'd0,    10'd0,    11'd0,    10'd0,    1'b1, 1'b0, 1'b0},
      '{mbre_pkg::ACT_GET_DOT,  11'd0,    10'd0,    11'd0,    10'd0,    1'b0, 1'b1, 1'b1},
      '{mbre_pkg::ACT_PUT_DOT,  11'd0,    10'd0,    11'd0,    10'd0,    1'b0, 1'b0, 1'b0},
      '{mbre_pkg::ACT_GET_DOT,  11'd0,    10'd0,    11'd0,    10'd0,    1'b0, 1'b1, 1'b0},
      '{mbre_pkg::ACT_PUT_DOT,  11'd2047, 10'd1023, 11'd0,    10'd0,    1'b1, 1'b0, 1'b0},
      '{mbre_pkg::ACT_GET_DOT,  11'd2047, 10'd1023, 11'd0,    10'd0,    1'b0, 1'b1, 1'b0},
      '{mbre_pkg::ACT_PUT_DOT,  11'd7,    10'd127,  11'd0,    10'd0,    1'b1, 1'b0, 1'b0},
      '{mbre_pkg::ACT_GET_DOT,  11'd7,    10'd127,  11'd0,    10'd0,    1'b0, 1'b1, 1'b1},
      '{mbre_pkg::ACT_GET_SEG,  11'd0,    10'd0,    11'd0,    10'd0,    1'b0, 1'b0, 1'b0},
      '{mbre_pkg::ACT_GET_SEG,  11'd0,    10'd127,  11'd2047, 10'd0,    1'b0, 1'b0, 1'b0},
      '{mbre_pkg::ACT_GET_SEG,  11'd2040, 10'd127,  11'd64,   10'd0,    1'b0, 1'b0, 1'b0},
      '{mbre_pkg::ACT_XOR_RECT, 11'd3,    10'd0,    11'd10,   10'd3,    1'b0, 1'b0, 1'b0},
      '{mbre_pkg::ACT_GET_SEG,  11'd0,    10'd1,    11'd16,   10'd0,    1'b0, 1'b0, 1'b0},
      '{mbre_pkg::ACT_XOR_RECT, 11'd9,    10'd4,    11'd3,    10'd1,    1'b0, 1'b0, 1'b0},
      '{mbre_pkg::ACT_XOR_RECT, 11'd2047, 10'd0,    11'd2047, 10'd1,    1'b0, 1'b0, 1'b0},
      '{mbre_pkg::ACT_XOR_RECT, 11'd0,    10'd1023, 11'd16,   10'd1023, 1'b0, 1'b0, 1'b0},
      '{mbre_pkg::ACT_GET_SEG,  11'd0,    10'd4,    11'd64,   10'd0,    1'b0, 1'b0, 1'b0},
      '{mbre_pkg::ACT_FILL,     11'd0,    10'd0,    11'd0,    10'd0,    1'b1, 1'b0, 1'b0},
      '{mbre_pkg::ACT_GET_DOT,  11'd100,  10'd50,   11'd0,    10'd0,    1'b0, 1'b1, 1'b1},
      '{ACT_RSVD_LO,  11'd2047, 10'd1023, 11'd2047, 10'd1023, 1'b1, 1'b0, 1'b0},
      '{ACT_RSVD_LO + 3'd1, 11'd5, 10'd5, 11'd5,    10'd5,    1'b0, 1'b0, 1'b0},
      '{ACT_RSVD_HI,  11'd1,    10'd1,    11'd64,   10'd1,    1'b1, 1'b0, 1'b0},
      '{mbre_pkg::ACT_GET_DOT,  11'd2047, 10'd127,  11'd0,    10'd0,    1'b0, 1'b1, 1'b1}
   };

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [2:0]                      req_action = mbre_pkg::ACT_PUT_DOT;
   logic [10:0]                     req_x = '0;
   logic [9:0]                      req_y = '0;
   logic [10:0]                     req_span_width = '0;
   logic [9:0]                      req_rect_height = '0;
   logic                            req_color = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_pixel;
   logic                            rsp_last;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [mbre_pkg::CSR_IDX_W-1:0]  csr_index = mbre_pkg::CSR_ROW_BYTES;
   logic [mbre_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic [7:0]     bitmap [0:MEM_BYTES-1];
   int             row_bytes_q = mbre_pkg::ROW_BYTES_RST;
   int             rows_q = mbre_pkg::ROWS_RST;
   pixel_word_type pixel_q [$];
   pixel_word_type want_w;
   int             mismatches = 0;
   int             quiet_cycles = 0;
   int             req_idle_pct = IDLE_PCT;
   int             rsp_stall_pct = IDLE_PCT;
   int             last_put_x = 0;
   int             last_put_y = 0;

   mono_bitmap_raster_engine_unit #(
      .MEM_BYTES(MEM_BYTES),
      .MAX_SPAN (MAX_SPAN)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_x          (req_x),
      .req_y          (req_y),
      .req_span_width (req_span_width),
      .req_rect_height(req_rect_height),
      .req_color      (req_color),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pixel      (rsp_pixel),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      mismatches++;
   endtask

   // ---- bitmap model -------------------------------------------------------

   function automatic logic [7:0] peek_byte(input int addr);
      return (addr < MEM_BYTES) ? bitmap[addr] : 8'h00;
   endfunction

   task automatic flip_byte(input int addr, input logic [7:0] mask);
      if (addr < MEM_BYTES) bitmap[addr] ^= mask;
   endtask

   function automatic bit dot_addr(input int x, input int y, output int addr);
      addr = y * row_bytes_q + (x >> 3);
      return ((x >> 3) < row_bytes_q) && (y < rows_q) && (addr < MEM_BYTES);
   endfunction

   task automatic xor_box(input int x, input int y, input int w, input int h);
      int          sb, eb, nrows, base, b;
      logic [7:0]  smask, emask;
      logic [11:0] right;
      right = 12'(x + w);
      sb    = x >> 3;
      eb    = int'(right) >> 3;
      smask = mbre_pkg::BYTE_ONES >> x[2:0];
      emask = ~(mbre_pkg::BYTE_ONES >> right[2:0]);
      if (sb < row_bytes_q) begin
         if (sb == eb) begin
            smask &= emask;
         end else if (eb >= row_bytes_q) begin
            eb    = row_bytes_q;
            emask = 8'h00;
         end
         if (y >= rows_q) nrows = 0;
         else if (h + y > rows_q) nrows = rows_q - y;
         else nrows = h;
         for (int r = 0; r < nrows; r++) begin
            base = (y + r) * row_bytes_q;
            flip_byte(base + sb, smask);
            for (b = sb + 1; b < eb; b++) flip_byte(base + b, mbre_pkg::BYTE_ONES);
            if (b == eb && emask != 8'h00) flip_byte(base + eb, emask);
         end
      end
   endtask

   // apply one command to the bitmap and queue the pixel words it returns
   task automatic raster_predict(input raster_cmd_type c);
      int             addr, n, size;
      logic [7:0]     bit_m;
      pixel_word_type w;
      bit_m = mbre_pkg::LEFT_BIT >> c.x[2:0];
      case (c.action)
         mbre_pkg::ACT_PUT_DOT: begin
            if (dot_addr(int'(c.x), int'(c.y), addr)) begin
               if (c.color) bitmap[addr] |= bit_m;
               else bitmap[addr] &= ~bit_m;
            end
         end
         mbre_pkg::ACT_GET_DOT: begin
            w.pixel = 1'b0;
            w.last  = 1'b1;
            if (dot_addr(int'(c.x), int'(c.y), addr)) w.pixel = |(bitmap[addr] & bit_m);
            pixel_q.push_back(w);
         end
         mbre_pkg::ACT_GET_SEG: begin
            n    = (int'(c.span) > MAX_SPAN) ? MAX_SPAN : int'(c.span);
            addr = int'(c.y) * row_bytes_q + (int'(c.x) >> 3);
            for (int i = 0; i < n; i++) begin
               w.pixel = |(peek_byte(addr) & bit_m);
               w.last  = (i + 1 == n);
               pixel_q.push_back(w);
               bit_m = bit_m >> 1;
               if (bit_m == 8'h00) begin
                  bit_m = mbre_pkg::LEFT_BIT;
                  addr++;
               end
            end
         end
         mbre_pkg::ACT_XOR_RECT: begin
            xor_box(int'(c.x), int'(c.y), int'(c.span), int'(c.height));
         end
         mbre_pkg::ACT_FILL: begin
            size = row_bytes_q * rows_q;
            if (size > MEM_BYTES) size = MEM_BYTES;
            for (int i = 0; i < size; i++) bitmap[i] = c.color ? mbre_pkg::BYTE_ONES : 8'h00;
         end
         default: begin
         end
      endcase
   endtask

   // ---- stimulus -----------------------------------------------------------

   function automatic raster_cmd_type rand_cmd();
      raster_cmd_type c;
      int             pick, sb, eb, nrows, yy;
      pick = $urandom_range(0, 9);
      if (pick < 4) c.span = 11'($urandom_range(0, 16));
      else if (pick < 8) c.span = 11'($urandom_range(0, 80));
      else c.span = 11'($urandom);
      c.x      = $urandom_range(0, 1) ? 11'($urandom_range(0, row_bytes_q * 8 - 1))
                                      : 11'($urandom);
      c.y      = $urandom_range(0, 1) ? 10'($urandom_range(0, rows_q - 1)) : 10'($urandom);
      c.height = ($urandom_range(0, 9) < 7) ? 10'($urandom_range(0, 8)) : 10'($urandom);
      c.color  = 1'($urandom_range(0, 1));
      pick = $urandom_range(0, 99);
      if (pick < 25) c.action = mbre_pkg::ACT_PUT_DOT;
      else if (pick < 45) c.action = mbre_pkg::ACT_GET_DOT;
      else if (pick < 65) c.action = mbre_pkg::ACT_GET_SEG;
      else if (pick < 90) c.action = mbre_pkg::ACT_XOR_RECT;
      else if (pick < 94) c.action = mbre_pkg::ACT_FILL;
      else c.action = 3'($urandom_range(ACT_RSVD_LO, ACT_RSVD_HI));
      // keep full-store fills rare, they walk every byte
      if (c.action == mbre_pkg::ACT_FILL && row_bytes_q * rows_q > FILL_BUDGET &&
          $urandom_range(0, 3) != 0)
         c.action = mbre_pkg::ACT_GET_DOT;
      if (c.action == mbre_pkg::ACT_PUT_DOT) begin
         last_put_x = c.x;
         last_put_y = c.y;
      end else if (c.action == mbre_pkg::ACT_GET_DOT && $urandom_range(0, 9) < 3) begin
         c.x = 11'(last_put_x);
         c.y = 10'(last_put_y);
      end
      if (c.action == mbre_pkg::ACT_XOR_RECT) begin
         sb = int'(c.x) >> 3;
         eb = (int'(c.x) + int'(c.span)) >> 3;
         if (eb >= row_bytes_q) eb = row_bytes_q;
         yy = int'(c.y);
         // shrink the box until its clipped byte count fits the budget
         for (int k = 0; k < 11; k++) begin
            if (yy >= rows_q) nrows = 0;
            else if (int'(c.height) + yy > rows_q) nrows = rows_q - yy;
            else nrows = int'(c.height);
            if (nrows * (eb - sb + 1) > XOR_BUDGET) c.height = c.height >> 1;
         end
      end
      return c;
   endfunction

   task automatic push_cmd(input raster_cmd_type c, input logic typed,
                           input logic exp_pixel);
      pixel_word_type w;
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_action      <= c.action;
      req_x           <= c.x;
      req_y           <= c.y;
      req_span_width  <= c.span;
      req_rect_height <= c.height;
      req_color       <= c.color;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      if (typed) begin
         w.pixel = exp_pixel;
         w.last  = 1'b1;
         pixel_q.push_back(w);
      end else begin
         raster_predict(c);
      end
   endtask

   task automatic write_reg(input logic [mbre_pkg::CSR_IDX_W-1:0] idx, input int value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= mbre_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == mbre_pkg::CSR_ROW_BYTES) row_bytes_q = value & 'h1FF;
      else rows_q = value & 'h7FF;
      @(posedge clock);
   endtask

   // the last word of a phase is a get dot, so once its pixel is in the
   // engine has finished every earlier command
   task automatic settle();
      while (pixel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      rsp_stall <= (rsp_stall_pct != 0) && ($urandom_range(0, 99) < rsp_stall_pct);
   end

   // ---- checking -----------------------------------------------------------

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pixel_q.size() == 0) begin
            report_mismatch("pixel word with none expected", rsp_pixel, 0);
         end else begin
            want_w = pixel_q.pop_front();
            if (rsp_pixel !== want_w.pixel) report_mismatch("pixel", rsp_pixel, want_w.pixel);
            if (rsp_last !== want_w.last) report_mismatch("last", rsp_last, want_w.last);
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("tb_mono_bitmap_raster_engine_unit NOT OK");
         $finish;
      end
   end

   initial begin
      raster_cmd_type c;
      dir_row_type    r;
      int             rb, nr;
      while (reset) @(posedge clock);

      // widest raster first so the opening fill writes every byte of the store
      write_reg(mbre_pkg::CSR_ROW_BYTES, 256);
      write_reg(mbre_pkg::CSR_ROWS, 1024);
      for (int i = 0; i < DIR_ROWS; i++) begin
         r = dir_tab[i];
         c = '{r.action, r.x, r.y, r.span, r.height, r.color};
         push_cmd(c, r.typed, r.exp_pixel);
      end
      req_valid <= 1'b0;
      settle();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0: begin rb = 1;   nr = 1;    end
            1: begin rb = 256; nr = 1024; end
            2: begin rb = 40;  nr = 200;  end
            3: begin rb = 1;   nr = 1024; end
            4: begin rb = 256; nr = 1;    end
            default: begin
               rb = $urandom_range(1, 256);
               nr = $urandom_range(1, 1024);
            end
         endcase
         write_reg(mbre_pkg::CSR_ROW_BYTES, rb);
         write_reg(mbre_pkg::CSR_ROWS, nr);
         // one phase runs with no idling on either side
         req_idle_pct  = (p == 2) ? 0 : IDLE_PCT;
         rsp_stall_pct = (p == 2) ? 0 : IDLE_PCT;
         for (int n = 0; n < ITEMS_PER_PHASE - 1; n++) push_cmd(rand_cmd(), 1'b0, 1'b0);
         c = rand_cmd();
         c.action = mbre_pkg::ACT_GET_DOT;
         push_cmd(c, 1'b0, 1'b0);
         req_valid <= 1'b0;
         settle();
      end

      if (mismatches == 0)
         $display("tb_mono_bitmap_raster_engine_unit OK");
      else
         $display("tb_mono_bitmap_raster_engine_unit NOT OK");
      $finish;
   end

endmodule

### mono_bitmap_raster_engine_unit.f
+incdir+sv
sv/mbre_pkg.sv
sv/mbre_store.sv
sv/mono_bitmap_raster_engine_unit.sv
test/tb_mono_bitmap_raster_engine_unit.sv
